// ===== hw/rtl/crf_gradient_scatter_accumulate_assert.svh =====
// Assertion macros for the gradient accumulator checker.
// Both sample on clk and stay quiet while rst is high.
`ifndef CRF_GRADIENT_SCATTER_ACCUMULATE_ASSERT_SVH
`define CRF_GRADIENT_SCATTER_ACCUMULATE_ASSERT_SVH

// Consequent in the same cycle as the antecedent.
`define CRF_GSA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crf_gsa assertion failed");

// Consequent in the cycle after the antecedent.
`define CRF_GSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crf_gsa assertion failed");

`endif

// ===== hw/rtl/crf_gsa_pkg.sv =====
package crf_gsa_pkg;

  localparam int KIND_W = 2;
  localparam int IDX_W  = 13;

  localparam logic [KIND_W-1:0] KIND_ACC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  localparam int MAX_STATES = 16;
  localparam int STATE_CMP_W = 9;

  localparam logic signed [15:0] ONE_Q14    = 16'sd16384;
  localparam logic signed [32:0] ROUND_BIAS = 33'sd8192;
  localparam int                 FRAC_SHIFT = 14;

endpackage

// ===== hw/rtl/crf_gsa_item_if.sv =====
interface crf_gsa_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [12:0]        param_index;
  logic signed [15:0] feature_value;
  logic [14:0]        belief;
  logic               edge_term;
  logic [3:0]         state_a;
  logic [3:0]         label_a;
  logic [3:0]         state_b;
  logic [3:0]         label_b;
  logic signed [31:0] write_value;

  modport source (
    output valid, kind, param_index, feature_value, belief, edge_term,
           state_a, label_a, state_b, label_b, write_value,
    input  ready
  );
  modport sink (
    input  valid, kind, param_index, feature_value, belief, edge_term,
           state_a, label_a, state_b, label_b, write_value,
    output ready
  );
endinterface

// ===== hw/rtl/crf_gsa_result_if.sv =====
interface crf_gsa_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic               saturated;

  modport source (output valid, read_value, saturated, input ready);
  modport sink (input valid, read_value, saturated, output ready);
endinterface

// ===== hw/rtl/crf_gradient_scatter_accumulate.sv =====
// CRF weight-gradient accumulator. A single-port-write, single-port-read memory of
// GRAD_ENTRIES signed Q19.12 words holds the gradient; after reset a clearing pass
// zeroes it one word a cycle, and no item is taken until it ends. Items are handled
// one at a time: a write goes straight to memory, a read passes through the memory
// read and then the output register (which stalls while a previous word is not yet
// taken), and an accumulate term through the memory read, a 16x16 multiply, then
// round, saturating add and write-back. A term with index 0 or above GRAD_ENTRIES,
// or with a state not below 16, and any item of kind three do nothing. Only reads
// return a word; saturated is a sticky flag set by any clipped accumulate since
// reset.
module crf_gradient_scatter_accumulate #(
  parameter int GRAD_ENTRIES = 4096
) (
  input logic              clk,
  input logic              rst,
  crf_gsa_item_if.sink     item,
  crf_gsa_result_if.source result
);
  import crf_gsa_pkg::*;

  localparam int AW = (GRAD_ENTRIES > 1) ? $clog2(GRAD_ENTRIES) : 1;
  localparam int XW = ((AW > IDX_W) ? AW : IDX_W) + 1;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_MUL, ST_ADD} state_t;

  state_t state;

  logic [31:0] grad_mem [GRAD_ENTRIES];

  logic [AW-1:0]      clr_addr;
  logic [AW-1:0]      addr;
  logic               is_read;
  logic               addr_ok;
  logic               sat_flag;
  logic signed [15:0] feature;
  logic signed [15:0] diff;
  logic signed [31:0] rd_data;
  logic signed [31:0] product;
  logic               out_valid;
  logic signed [31:0] out_value;
  logic               out_sat;

  logic               take;
  logic               load_out;
  logic [XW-1:0]      idx_ext;
  logic               in_ok;
  logic [AW-1:0]      in_addr;
  logic               states_ok;
  logic               indicator;
  logic signed [15:0] diff_next;
  logic signed [32:0] rounded;
  logic signed [33:0] sum;
  logic               overflow;
  logic signed [31:0] sum_sat;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [31:0]        wdata;

  assign item.ready        = (state == ST_IDLE);
  assign result.valid      = out_valid;
  assign result.read_value = out_value;
  assign result.saturated  = out_sat;

  assign take     = item.valid && item.ready;
  assign load_out = (state == ST_MUL) && is_read && (!out_valid || result.ready);
  assign idx_ext  = XW'(item.param_index);
  assign in_ok    = (idx_ext != '0) && (idx_ext <= XW'(GRAD_ENTRIES));
  assign in_addr  = AW'(idx_ext - XW'(1));

  assign states_ok = (STATE_CMP_W'(item.state_a) < STATE_CMP_W'(MAX_STATES)) &&
                     (!item.edge_term ||
                      (STATE_CMP_W'(item.state_b) < STATE_CMP_W'(MAX_STATES)));
  assign indicator = (item.state_a == item.label_a) &&
                     (!item.edge_term || (item.state_b == item.label_b));
  assign diff_next = $signed({1'b0, item.belief}) - (indicator ? ONE_Q14 : 16'sd0);

  assign rounded  = ($signed({product[31], product}) + ROUND_BIAS) >>> FRAC_SHIFT;
  assign sum      = $signed({rd_data[31], rd_data[31], rd_data}) +
                    $signed({rounded[32], rounded});
  assign overflow = (sum[33:31] != 3'b000) && (sum[33:31] != 3'b111);
  assign sum_sat  = overflow ? (sum[33] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sum[31:0];

  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wdata = '0;
    case (state)
      ST_CLEAR: begin
        we = 1'b1;
      end
      ST_IDLE: begin
        if (take && (item.kind == KIND_WRITE) && in_ok) begin
          we    = 1'b1;
          waddr = in_addr;
          wdata = item.write_value;
        end
      end
      ST_ADD: begin
        we    = 1'b1;
        waddr = addr;
        wdata = sum_sat;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      grad_mem[waddr] <= wdata;
    end
    if (take) begin
      rd_data <= grad_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      sat_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(GRAD_ENTRIES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (take) begin
            addr    <= in_addr;
            addr_ok <= in_ok;
            feature <= item.feature_value;
            diff    <= diff_next;
            is_read <= (item.kind == KIND_READ);
            if ((item.kind == KIND_READ) ||
                ((item.kind == KIND_ACC) && in_ok && states_ok)) begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          product <= 32'(feature) * 32'(diff);
          if (is_read) begin
            if (load_out) begin
              out_value <= addr_ok ? rd_data : 32'sd0;
              out_sat   <= sat_flag;
              state     <= ST_IDLE;
            end
          end else begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          if (overflow) begin
            sat_flag <= 1'b1;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/crf_gsa_checker.sv =====
`include "crf_gradient_scatter_accumulate_assert.svh"

module crf_gsa_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic [1:0]        item_kind,
  input logic              result_valid,
  input logic              result_ready,
  input logic signed [31:0] result_read_value,
  input logic              result_saturated
);
  import crf_gsa_pkg::*;

  logic seen_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_sat <= 1'b0;
    end else if (result_valid && result_ready && result_saturated) begin
      seen_sat <= 1'b1;
    end
  end

  `CRF_GSA_ASSERT_SAME(a_clear_after_reset, $past(rst), !item_ready)
  `CRF_GSA_ASSERT_NEXT(a_read_holds_off, item_valid && item_ready && item_kind == KIND_READ, !item_ready)
  `CRF_GSA_ASSERT_SAME(a_sat_sticky, result_valid && seen_sat, result_saturated)
  `CRF_GSA_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_read_value) && $stable(result_saturated))

endmodule

bind crf_gradient_scatter_accumulate crf_gsa_checker u_crf_gsa_checker (
  .clk               (clk),
  .rst               (rst),
  .item_valid        (item.valid),
  .item_ready        (item.ready),
  .item_kind         (item.kind),
  .result_valid      (result.valid),
  .result_ready      (result.ready),
  .result_read_value (result.read_value),
  .result_saturated  (result.saturated)
);
